// ===== rtl/integer_expression_evaluator_defines.svh =====
// assertion macros used by the checker file
`ifndef INTEGER_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INTEGER_EXPRESSION_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define IEE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("iee checker: property failed");

// next-cycle implication
`define IEE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("iee checker: property failed");

`endif

// ===== rtl/iee_pkg.sv =====
package iee_pkg;

	// operator codes as kept on the operator stack
	typedef logic [3:0] op_t;

	localparam op_t OP_NONE  = 4'd0;
	localparam op_t OP_MUL   = 4'd1;
	localparam op_t OP_DIV   = 4'd2;
	localparam op_t OP_MOD   = 4'd3;
	localparam op_t OP_ADD   = 4'd4;
	localparam op_t OP_SUB   = 4'd5;
	localparam op_t OP_SHL   = 4'd6;
	localparam op_t OP_SHR   = 4'd7;
	localparam op_t OP_AND   = 4'd8;
	localparam op_t OP_XOR   = 4'd9;
	localparam op_t OP_OR    = 4'd10;
	localparam op_t OP_NEG   = 4'd11;
	localparam op_t OP_NOT   = 4'd12;
	localparam op_t OP_PAREN = 4'd13;

	// reduce level that takes every binary operator
	localparam logic [3:0] LVL_TOP = 4'd9;

	// value that marks an expression as invalid
	localparam logic [31:0] RESERVED_VALUE = 32'h8000_0001;

	// divider response
	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

	// binding strength, lower binds tighter
	function automatic logic [3:0] op_level(input op_t op);
		logic [3:0] lvl;
		if (op <= OP_MOD) lvl = 4'd1;
		else if (op <= OP_SUB) lvl = 4'd2;
		else if (op <= OP_SHR) lvl = 4'd3;
		else if (op == OP_AND) lvl = 4'd4;
		else if (op == OP_XOR) lvl = 4'd5;
		else lvl = 4'd6;
		return lvl;
	endfunction

endpackage

// ===== rtl/integer_expression_evaluator.sv =====
// channel  dir  signals                          item
// s        in   s_tvalid s_tready s_tdata s_tlast  one expression character
// m        out  m_tvalid m_tready m_tdata m_tuser  value and valid flag
//
// one character at a time, taken in S_IDLE and worked through the sequencer;
// each binary reduction runs S_RD, S_EX and S_WB, and a divide or modulo
// also waits in S_DIV on the 32-step divider; stack reads are registered
// reset clears state, counters and flags only, the stack memories need no clearing
// the result sits in an output register; s_tready does not wait for it to be taken,
// only a second result stalls until the first is taken
module integer_expression_evaluator
	import iee_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] value
	output logic [0:0]  m_tuser   // [0] valid_res
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_FEED    = 4'd1;
	localparam logic [3:0] S_AFTER   = 4'd2;
	localparam logic [3:0] S_CP      = 4'd3;
	localparam logic [3:0] S_CP_RD   = 4'd4;
	localparam logic [3:0] S_RED     = 4'd5;
	localparam logic [3:0] S_RD      = 4'd6;
	localparam logic [3:0] S_EX      = 4'd7;
	localparam logic [3:0] S_DIV     = 4'd8;
	localparam logic [3:0] S_WB      = 4'd9;
	localparam logic [3:0] S_POST    = 4'd10;
	localparam logic [3:0] S_DONE_CH = 4'd11;
	localparam logic [3:0] S_EOI     = 4'd12;
	localparam logic [3:0] S_EMIT    = 4'd13;

	// parse phases
	localparam logic [2:0] PH_OPND  = 3'd0;
	localparam logic [2:0] PH_LIT   = 3'd1;
	localparam logic [2:0] PH_AFTER = 3'd2;
	localparam logic [2:0] PH_LT    = 3'd3;
	localparam logic [2:0] PH_GT    = 3'd4;

	// literal radix phases
	localparam logic [2:0] RX_NONE  = 3'd0;
	localparam logic [2:0] RX_ZERO  = 3'd1;
	localparam logic [2:0] RX_ZEROX = 3'd2;
	localparam logic [2:0] RX_OCT   = 3'd3;
	localparam logic [2:0] RX_DEC   = 3'd4;
	localparam logic [2:0] RX_HEX   = 3'd5;

	// what follows a completed primary
	localparam logic [1:0] K_NONE  = 2'd0;
	localparam logic [1:0] K_AFTER = 2'd1;
	localparam logic [1:0] K_UNEXP = 2'd2;

	// what follows a reduce run
	localparam logic [1:0] R_BIN   = 2'd0;
	localparam logic [1:0] R_CLOSE = 2'd1;
	localparam logic [1:0] R_FIN   = 2'd2;

	// shared actions of the sequencer
	localparam logic [2:0] A_NONE   = 3'd0;
	localparam logic [2:0] A_DONE   = 3'd1;
	localparam logic [2:0] A_FAIL   = 3'd2;
	localparam logic [2:0] A_UNEXP  = 3'd3;
	localparam logic [2:0] A_REDUCE = 3'd4;
	localparam logic [2:0] A_ENDLIT = 3'd5;
	localparam logic [2:0] A_PUSHOP = 3'd6;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] d;
		if (c >= "0" && c <= "9") d = 5'(c - "0");
		else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
		else d = 5'd16;
		return d;
	endfunction

	// control registers
	logic [3:0]    state_q, n_state;
	logic [2:0]    phase_q, n_phase;
	logic [2:0]    rx_q, n_rx;
	logic [30:0]   accum_q, n_accum;
	logic [CW-1:0] ocnt_q, n_ocnt;
	logic [CW-1:0] pcnt_q, n_pcnt;
	logic [CW-1:0] depth_q, n_depth;
	logic          fin_q, n_fin;
	logic          err_q, n_err;

	// payload registers
	logic [7:0]  c_q, n_c;
	logic        last_q, n_last;
	logic [31:0] top_v_q, n_top_v;
	op_t         top_op_q, n_top_op;
	logic [31:0] final_q, n_final;
	logic [31:0] cp_v_q, n_cp_v;
	logic [1:0]  cont_q, n_cont;
	logic        inplace_q, n_inplace;
	logic [3:0]  lvl_q, n_lvl;
	logic [1:0]  post_q, n_post;
	op_t         pend_q, n_pend;
	logic [31:0] a_q, n_a;
	logic [31:0] b_q, n_b;
	op_t         exop_q, n_exop;
	logic [31:0] r_q, n_r;

	// output register
	logic        m_tvalid_q;
	logic [31:0] out_value_q;
	logic        out_ok_q;
	logic        out_load;

	// stack memories; the top entry of each stack lives in top_v_q / top_op_q
	logic [31:0] opd_mem [STACK_DEPTH];
	op_t         opr_mem [STACK_DEPTH];
	logic [31:0] opd_rd_q;
	op_t         opr_rd_q;
	logic          opd_we, opr_we;
	logic [CW-1:0] ocnt_m1, ocnt_m2, pcnt_m1, pcnt_m2;

	// divider
	logic        div_start;
	logic [31:0] a_mag, b_mag;
	div_rsp_t    div_rsp;
	logic [31:0] quo_s, rem_s;

	// alu
	logic [63:0] prod;
	logic [31:0] shr_res;

	// literal accumulate
	logic [4:0]  dig;
	logic [35:0] acc8, acc10, acc16;

	// action interface
	logic [2:0] act;
	logic [1:0] act_cont;
	logic [1:0] act_post;
	op_t        act_op;
	logic [31:0] neg_v;

	assign ocnt_m1 = ocnt_q - CW'(1);
	assign ocnt_m2 = ocnt_q - CW'(2);
	assign pcnt_m1 = pcnt_q - CW'(1);
	assign pcnt_m2 = pcnt_q - CW'(2);

	// memory ports: writes only on push, reads issued every cycle one below the top
	always_ff @(posedge clk) begin
		if (opd_we) opd_mem[ocnt_m1[AW-1:0]] <= top_v_q;
		if (opr_we) opr_mem[pcnt_m1[AW-1:0]] <= top_op_q;
		opd_rd_q <= opd_mem[ocnt_m2[AW-1:0]];
		opr_rd_q <= opr_mem[pcnt_m2[AW-1:0]];
	end

	assign dig   = hex_val(c_q);
	assign acc8  = {2'b0, accum_q, 3'b0} + 36'(dig);
	assign acc16 = {1'b0, accum_q, 4'b0} + 36'(dig);
	assign acc10 = {2'b0, accum_q, 3'b0} + {4'b0, accum_q, 1'b0} + 36'(dig);

	assign prod    = a_q * b_q;
	assign shr_res = $signed(a_q) >>> b_q[4:0];
	assign a_mag   = a_q[31] ? (32'd0 - a_q) : a_q;
	assign b_mag   = b_q[31] ? (32'd0 - b_q) : b_q;
	assign quo_s   = (a_q[31] ^ b_q[31]) ? (32'd0 - div_rsp.quo) : div_rsp.quo;
	assign rem_s   = a_q[31] ? (32'd0 - div_rsp.rem) : div_rsp.rem;
	assign neg_v   = (top_op_q == OP_NEG) ? (32'd0 - cp_v_q) : ~cp_v_q;

	iee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_mag),
		.divisor  (b_mag),
		.rsp      (div_rsp)
	);

	// sequencer
	always_comb begin
		n_state = state_q;   n_phase = phase_q;   n_rx = rx_q;
		n_accum = accum_q;   n_ocnt = ocnt_q;     n_pcnt = pcnt_q;
		n_depth = depth_q;   n_fin = fin_q;       n_err = err_q;
		n_c = c_q;           n_last = last_q;     n_top_v = top_v_q;
		n_top_op = top_op_q; n_final = final_q;   n_cp_v = cp_v_q;
		n_cont = cont_q;     n_inplace = inplace_q;
		n_lvl = lvl_q;       n_post = post_q;     n_pend = pend_q;
		n_a = a_q;           n_b = b_q;           n_exop = exop_q;
		n_r = r_q;
		opd_we = 1'b0;  opr_we = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		act = A_NONE;  act_cont = K_NONE;  act_post = R_BIN;  act_op = OP_NONE;

		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					n_c = s_tdata;
					n_last = s_tlast;
					n_state = fin_q ? S_DONE_CH : S_FEED;
				end
			end
			S_FEED: begin
				case (phase_q)
					PH_OPND: begin
						if (c_q == " " || c_q == "+") act = A_DONE;
						else if (c_q == "-") begin
							act = A_PUSHOP; act_op = OP_NEG;
						end else if (c_q == "~") begin
							act = A_PUSHOP; act_op = OP_NOT;
						end else if (c_q == "(") begin
							act = A_PUSHOP; act_op = OP_PAREN;
							n_depth = depth_q + CW'(1);
						end else if (c_q == "0") begin
							n_phase = PH_LIT; n_rx = RX_ZERO; n_accum = '0;
							act = A_DONE;
						end else if (c_q >= "1" && c_q <= "9") begin
							n_phase = PH_LIT; n_rx = RX_DEC; n_accum = 31'(dig);
							act = A_DONE;
						end else act = A_FAIL;
					end
					PH_LIT: begin
						case (rx_q)
							RX_ZERO: begin
								if (c_q == "x" || c_q == "X") begin
									n_rx = RX_ZEROX; act = A_DONE;
								end else if (dig < 5'd8) begin
									n_rx = RX_OCT;
									n_accum = (acc8 > 36'h7fff_ffff) ? 31'h7fff_ffff : acc8[30:0];
									act = A_DONE;
								end else begin
									act = A_ENDLIT; act_cont = K_AFTER;
								end
							end
							RX_ZEROX: begin
								if (dig < 5'd16) begin
									n_rx = RX_HEX;
									n_accum = (acc16 > 36'h7fff_ffff) ? 31'h7fff_ffff : acc16[30:0];
									act = A_DONE;
								end else begin
									act = A_ENDLIT; act_cont = K_UNEXP;
								end
							end
							RX_OCT: begin
								if (dig < 5'd8) begin
									n_accum = (acc8 > 36'h7fff_ffff) ? 31'h7fff_ffff : acc8[30:0];
									act = A_DONE;
								end else begin
									act = A_ENDLIT; act_cont = K_AFTER;
								end
							end
							RX_DEC: begin
								if (dig < 5'd10) begin
									n_accum = (acc10 > 36'h7fff_ffff) ? 31'h7fff_ffff : acc10[30:0];
									act = A_DONE;
								end else begin
									act = A_ENDLIT; act_cont = K_AFTER;
								end
							end
							RX_HEX: begin
								if (dig < 5'd16) begin
									n_accum = (acc16 > 36'h7fff_ffff) ? 31'h7fff_ffff : acc16[30:0];
									act = A_DONE;
								end else begin
									act = A_ENDLIT; act_cont = K_AFTER;
								end
							end
							default: begin
								act = A_ENDLIT; act_cont = K_AFTER;
							end
						endcase
					end
					PH_AFTER: n_state = S_AFTER;
					PH_LT: begin
						if (c_q == "<") begin
							act = A_REDUCE; act_post = R_BIN; act_op = OP_SHL;
						end else act = A_UNEXP;
					end
					default: begin
						if (c_q == ">") begin
							act = A_REDUCE; act_post = R_BIN; act_op = OP_SHR;
						end else act = A_UNEXP;
					end
				endcase
			end
			S_AFTER: begin
				act = A_REDUCE; act_post = R_BIN;
				case (c_q)
					" ": act = A_DONE;
					"+": act_op = OP_ADD;
					"-": act_op = OP_SUB;
					"*": act_op = OP_MUL;
					"/": act_op = OP_DIV;
					"%": act_op = OP_MOD;
					"&": act_op = OP_AND;
					"^": act_op = OP_XOR;
					"|": act_op = OP_OR;
					"<": begin
						n_phase = PH_LT; act = A_DONE;
					end
					">": begin
						n_phase = PH_GT; act = A_DONE;
					end
					")": begin
						if (depth_q != '0) act_post = R_CLOSE;
						else act = A_UNEXP;
					end
					default: act = A_UNEXP;
				endcase
			end
			S_CP: begin
				// strip pending unary operators, then push the value or, in place, leave it on top
				if (pcnt_q != '0 && (top_op_q == OP_NEG || top_op_q == OP_NOT)) begin
					if (neg_v == RESERVED_VALUE) act = A_FAIL;
					else begin
						n_cp_v = neg_v;
						n_pcnt = pcnt_m1;
						n_state = S_CP_RD;
					end
				end else if (!inplace_q && ocnt_q >= CW'(STACK_DEPTH)) begin
					act = A_FAIL;
				end else begin
					if (!inplace_q) begin
						opd_we = (ocnt_q != '0);
						n_ocnt = ocnt_q + CW'(1);
					end
					n_top_v = cp_v_q;
					n_phase = PH_AFTER;
					case (cont_q)
						K_AFTER: n_state = S_AFTER;
						K_UNEXP: act = A_UNEXP;
						default: act = A_DONE;
					endcase
				end
			end
			S_CP_RD: begin
				n_top_op = opr_rd_q;
				n_state = S_CP;
			end
			S_RED: begin
				if (fin_q || pcnt_q == '0) n_state = S_POST;
				else if (top_op_q < OP_MUL || top_op_q > OP_OR || op_level(top_op_q) > lvl_q)
					n_state = S_POST;
				else if (ocnt_q < CW'(2)) act = A_FAIL;
				else n_state = S_RD;
			end
			S_RD: begin
				n_a = opd_rd_q;
				n_b = top_v_q;
				n_exop = top_op_q;
				n_top_op = opr_rd_q;
				n_pcnt = pcnt_m1;
				n_ocnt = ocnt_m1;
				n_state = S_EX;
			end
			S_EX: begin
				n_state = S_WB;
				case (exop_q) inside
					OP_MUL: n_r = prod[31:0];
					OP_DIV, OP_MOD: begin
						if (b_q == '0) act = A_FAIL;
						else begin
							div_start = 1'b1;
							n_state = S_DIV;
						end
					end
					OP_ADD: n_r = a_q + b_q;
					OP_SUB: n_r = a_q - b_q;
					OP_SHL: begin
						if (b_q == '0) act = A_FAIL;
						else n_r = a_q << b_q[4:0];
					end
					OP_SHR: begin
						if (b_q == '0) act = A_FAIL;
						else n_r = shr_res;
					end
					OP_AND: n_r = a_q & b_q;
					OP_XOR: n_r = a_q ^ b_q;
					OP_OR: n_r = a_q | b_q;
					default: act = A_FAIL;
				endcase
			end
			S_DIV: begin
				if (div_rsp.done) begin
					n_r = (exop_q == OP_DIV) ? quo_s : rem_s;
					n_state = S_WB;
				end
			end
			S_WB: begin
				if (r_q == RESERVED_VALUE) act = A_FAIL;
				else begin
					n_top_v = r_q;
					n_state = S_RED;
				end
			end
			S_POST: begin
				case (post_q)
					R_BIN: begin
						if (fin_q) act = A_DONE;
						else begin
							act = A_PUSHOP; act_op = pend_q;
							n_phase = PH_OPND;
						end
					end
					R_CLOSE: begin
						if (fin_q) act = A_DONE;
						else if (pcnt_q == '0 || top_op_q != OP_PAREN || ocnt_q == '0)
							act = A_FAIL;
						else begin
							// the value stays on top and is finished in place
							n_pcnt = pcnt_m1;
							n_depth = depth_q - CW'(1);
							n_cp_v = top_v_q;
							n_inplace = 1'b1;
							n_cont = K_NONE;
							n_state = S_CP_RD;
						end
					end
					default: begin
						if (!err_q) begin
							if (ocnt_q == CW'(1) && pcnt_q == '0) n_final = top_v_q;
							else n_err = 1'b1;
						end
						n_fin = 1'b1;
						act = A_DONE;
					end
				endcase
			end
			S_DONE_CH: begin
				if (!last_q) n_state = S_IDLE;
				else n_state = fin_q ? S_EMIT : S_EOI;
			end
			S_EOI: begin
				case (phase_q)
					PH_OPND: act = A_FAIL;
					PH_LIT: begin
						act = A_ENDLIT; act_cont = K_UNEXP;
					end
					default: act = A_UNEXP;
				endcase
			end
			S_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					n_ocnt = '0;  n_pcnt = '0;  n_depth = '0;
					n_accum = '0; n_rx = RX_NONE; n_phase = PH_OPND;
					n_fin = 1'b0; n_err = 1'b0;
					n_state = S_IDLE;
				end
			end
			default: n_state = S_IDLE;
		endcase

		// shared actions
		case (act)
			A_DONE: n_state = S_DONE_CH;
			A_FAIL: begin
				n_err = 1'b1; n_fin = 1'b1; n_state = S_DONE_CH;
			end
			A_UNEXP: begin
				if (depth_q == '0) begin
					n_lvl = LVL_TOP; n_post = R_FIN; n_state = S_RED;
				end else begin
					n_err = 1'b1; n_fin = 1'b1; n_state = S_DONE_CH;
				end
			end
			A_REDUCE: begin
				n_lvl = (act_post == R_BIN) ? op_level(act_op) : LVL_TOP;
				n_post = act_post;
				n_pend = act_op;
				n_state = S_RED;
			end
			A_ENDLIT: begin
				n_cp_v = {1'b0, accum_q};
				n_accum = '0;
				n_rx = RX_NONE;
				n_inplace = 1'b0;
				n_cont = act_cont;
				n_state = S_CP;
			end
			A_PUSHOP: begin
				if (pcnt_q >= CW'(STACK_DEPTH)) begin
					n_err = 1'b1; n_fin = 1'b1;
				end else begin
					opr_we = (pcnt_q != '0);
					n_top_op = act_op;
					n_pcnt = pcnt_q + CW'(1);
				end
				n_state = S_DONE_CH;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_OPND;
			rx_q    <= RX_NONE;
			accum_q <= '0;
			ocnt_q  <= '0;
			pcnt_q  <= '0;
			depth_q <= '0;
			fin_q   <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			state_q <= n_state;
			phase_q <= n_phase;
			rx_q    <= n_rx;
			accum_q <= n_accum;
			ocnt_q  <= n_ocnt;
			pcnt_q  <= n_pcnt;
			depth_q <= n_depth;
			fin_q   <= n_fin;
			err_q   <= n_err;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		c_q       <= n_c;
		last_q    <= n_last;
		top_v_q   <= n_top_v;
		top_op_q  <= n_top_op;
		final_q   <= n_final;
		cp_v_q    <= n_cp_v;
		cont_q    <= n_cont;
		inplace_q <= n_inplace;
		lvl_q     <= n_lvl;
		post_q    <= n_post;
		pend_q    <= n_pend;
		a_q       <= n_a;
		b_q       <= n_b;
		exop_q    <= n_exop;
		r_q       <= n_r;
	end

	// output item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= err_q ? 32'd0 : final_q;
			out_ok_q    <= !err_q;
		end
	end

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = out_value_q;
	assign m_tuser[0] = out_ok_q;

endmodule

// ===== rtl/iee_div.sv =====
module iee_div
	import iee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output div_rsp_t    rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [32:0] shifted;
	logic [32:0] trial;
	logic        fits;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, dvd_q[31]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign fits    = !trial[32];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[31:0] : shifted[31:0];
			dvd_q <= {dvd_q[30:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/iee_checker.sv =====
`include "integer_expression_evaluator_defines.svh"

module iee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result stays offered
	`IEE_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// an invalid result carries a zero value
	`IEE_ASSERT_IMP(a_bad_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == 32'd0)

	// the block is busy in the cycle after each accepted item
	`IEE_ASSERT_NXT(a_busy_after, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a new result comes only out of a busy cycle
	`IEE_ASSERT_IMP(a_rise_busy, clk, arst_n, $rose(m_tvalid), !$past(s_tready))

endmodule

bind integer_expression_evaluator iee_checker u_iee_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== test/tb_top.sv =====
module tb_top;
	import iee_pkg::*;

	typedef enum int {PH_OPND, PH_LIT, PH_AFTER, PH_LT, PH_GT} phase_e;
	typedef enum int {RX_NONE, RX_ZERO, RX_ZEROX, RX_OCT, RX_DEC, RX_HEX} radix_e;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct {
		logic [31:0] value;
		logic        ok;
	} eval_res_t;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 800000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	char_item_t pend_q[$];
	eval_res_t  expected_q[$];
	int         sent_cnt = 0;
	int         err_cnt = 0;
	int         hold_cnt = 0;
	bit         hold_done = 0;
	int         cycle_cnt = 0;

	// evaluator shadow state
	logic [31:0] vstk[DEPTH];
	logic [3:0]  ostk[DEPTH];
	int          vn, on, pdepth;
	logic [31:0] lit_acc;
	radix_e      radix;
	phase_e      phase;
	bit          fin, bad;
	logic [31:0] fin_val;

	integer_expression_evaluator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// reset
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void ev_clear();
		vn = 0; on = 0; pdepth = 0; lit_acc = 0;
		radix = RX_NONE; phase = PH_OPND; fin = 0; bad = 0; fin_val = 0;
	endfunction

	function automatic void ev_fail();
		bad = 1; fin = 1;
	endfunction

	function automatic int prec(logic [3:0] op);
		if (op <= OP_MOD) return 1;
		if (op <= OP_SUB) return 2;
		if (op <= OP_SHR) return 3;
		if (op == OP_AND) return 4;
		if (op == OP_XOR) return 5;
		return 6;
	endfunction

	function automatic void push_val(logic [31:0] v);
		if (vn >= DEPTH) begin ev_fail(); return; end
		vstk[vn] = v; vn++;
	endfunction

	function automatic void push_op(logic [3:0] op);
		if (on >= DEPTH) begin ev_fail(); return; end
		ostk[on] = op; on++;
	endfunction

	function automatic void reduce_one();
		logic [31:0] a, b, r;
		logic [3:0] op;
		if (vn < 2 || on == 0) begin ev_fail(); return; end
		on--; op = ostk[on];
		vn--; b = vstk[vn];
		a = vstk[vn - 1];
		r = 0;
		case (op) inside
			OP_MUL: r = a * b;
			OP_DIV, OP_MOD: begin
				if (b == 0) begin ev_fail(); return; end
				if (a == 32'h8000_0000 && b == 32'hffff_ffff)
					r = (op == OP_DIV) ? 32'h8000_0000 : 32'd0;
				else if (op == OP_DIV)
					r = $signed(a) / $signed(b);
				else
					r = $signed(a) % $signed(b);
			end
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_SHL: begin
				if (b == 0) begin ev_fail(); return; end
				r = a << b[4:0];
			end
			OP_SHR: begin
				if (b == 0) begin ev_fail(); return; end
				r = $signed(a) >>> b[4:0];
			end
			OP_AND: r = a & b;
			OP_XOR: r = a ^ b;
			OP_OR:  r = a | b;
			default: begin ev_fail(); return; end
		endcase
		if (r == RESERVED_VALUE) begin ev_fail(); return; end
		vstk[vn - 1] = r;
	endfunction

	function automatic void reduce_upto(int lvl);
		logic [3:0] top;
		while (!fin && on > 0) begin
			top = ostk[on - 1];
			if (top < OP_MUL || top > OP_OR || prec(top) > lvl) break;
			reduce_one();
		end
	endfunction

	function automatic void finish_top();
		reduce_upto(LVL_TOP);
		if (!bad) begin
			if (vn == 1 && on == 0) fin_val = vstk[0];
			else ev_fail();
		end
		fin = 1;
	endfunction

	function automatic void stray_char();
		if (pdepth == 0) finish_top();
		else ev_fail();
	endfunction

	// apply pending unary operators, then push
	function automatic void primary_done(logic [31:0] v);
		logic [3:0] top;
		while (on > 0) begin
			top = ostk[on - 1];
			if (top != OP_NEG && top != OP_NOT) break;
			on--;
			v = (top == OP_NEG) ? -v : ~v;
			if (v == RESERVED_VALUE) begin ev_fail(); return; end
		end
		push_val(v);
		phase = PH_AFTER;
	endfunction

	function automatic void binop(logic [3:0] op);
		reduce_upto(prec(op));
		if (fin) return;
		push_op(op);
		phase = PH_OPND;
	endfunction

	function automatic void close_paren();
		logic [31:0] v;
		reduce_upto(LVL_TOP);
		if (fin) return;
		if (on == 0 || ostk[on - 1] != OP_PAREN || vn == 0) begin ev_fail(); return; end
		on--; pdepth--;
		vn--; v = vstk[vn];
		primary_done(v);
	endfunction

	function automatic void lit_end();
		logic [31:0] v;
		v = lit_acc;
		lit_acc = 0;
		radix = RX_NONE;
		primary_done(v);
	endfunction

	function automatic int digit_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 16;
	endfunction

	// saturating accumulate
	function automatic void lit_add(int base, int d);
		logic [63:0] t;
		t = {32'd0, lit_acc} * base + d;
		lit_acc = (t > 64'h7fff_ffff) ? 32'h7fff_ffff : t[31:0];
	endfunction

	function automatic void after_operand(logic [7:0] c);
		case (c)
			" ": ;
			"+": binop(OP_ADD);
			"-": binop(OP_SUB);
			"*": binop(OP_MUL);
			"/": binop(OP_DIV);
			"%": binop(OP_MOD);
			"&": binop(OP_AND);
			"^": binop(OP_XOR);
			"|": binop(OP_OR);
			"<": phase = PH_LT;
			">": phase = PH_GT;
			")": if (pdepth > 0) close_paren(); else stray_char();
			default: stray_char();
		endcase
	endfunction

	function automatic void in_literal(logic [7:0] c);
		int d;
		d = digit_of(c);
		case (radix)
			RX_ZERO: begin
				if (c == "x" || c == "X") begin radix = RX_ZEROX; return; end
				if (d < 8) begin radix = RX_OCT; lit_add(8, d); return; end
			end
			RX_ZEROX: begin
				if (d < 16) begin radix = RX_HEX; lit_add(16, d); return; end
				lit_end();
				if (!fin) stray_char();
				return;
			end
			RX_OCT: if (d < 8) begin lit_add(8, d); return; end
			RX_DEC: if (d < 10) begin lit_add(10, d); return; end
			RX_HEX: if (d < 16) begin lit_add(16, d); return; end
			default: ;
		endcase
		lit_end();
		if (!fin) after_operand(c);
	endfunction

	function automatic void feed_char(logic [7:0] c);
		case (phase)
			PH_OPND: begin
				if (c == " " || c == "+") return;
				if (c == "-") push_op(OP_NEG);
				else if (c == "~") push_op(OP_NOT);
				else if (c == "(") begin push_op(OP_PAREN); pdepth++; end
				else if (c == "0") begin phase = PH_LIT; radix = RX_ZERO; lit_acc = 0; end
				else if (c >= "1" && c <= "9") begin
					phase = PH_LIT; radix = RX_DEC; lit_acc = c - "0";
				end
				else ev_fail();
			end
			PH_LIT:   in_literal(c);
			PH_AFTER: after_operand(c);
			PH_LT:    if (c == "<") binop(OP_SHL); else stray_char();
			default:  if (c == ">") binop(OP_SHR); else stray_char();
		endcase
	endfunction

	function automatic void input_end();
		case (phase)
			PH_OPND: ev_fail();
			PH_LIT: begin
				if (radix == RX_ZEROX) begin
					lit_end();
					if (!fin) stray_char();
				end else begin
					lit_end();
					if (!fin) begin
						if (pdepth > 0) ev_fail(); else finish_top();
					end
				end
			end
			PH_AFTER: if (pdepth > 0) ev_fail(); else finish_top();
			default: stray_char();
		endcase
	endfunction

	// one character into the shadow evaluator, expected result on last
	function automatic void eval_char(logic [7:0] c, logic last);
		eval_res_t r;
		if (!fin) feed_char(c);
		if (!last) return;
		if (!fin) input_end();
		r.value = bad ? 32'd0 : fin_val;
		r.ok = !bad;
		expected_q.push_back(r);
		ev_clear();
	endfunction

	function automatic void add_expr(string s);
		char_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.ch = s[i];
			it.last = (i == s.len() - 1);
			pend_q.push_back(it);
		end
	endfunction

	function automatic string rand_space();
		return ($urandom_range(0, 5) == 0) ? " " : "";
	endfunction

	function automatic string rand_literal();
		case ($urandom_range(0, 6)) inside
			[0:2]: return $sformatf("%0d", $urandom_range(1, 99));
			3: return $sformatf("0x%0h", $urandom());
			4: return $sformatf("0%0o", $urandom_range(0, 4095));
			5: return $sformatf("%0d", $urandom());
			default: return $sformatf("0X%0H", $urandom_range(0, 255));
		endcase
	endfunction

	function automatic string rand_operand(int d);
		int k;
		k = $urandom_range(0, 9);
		if (k < 6 || d >= 3) return {rand_space(), rand_literal(), rand_space()};
		if (k < 8) begin
			case ($urandom_range(0, 2))
				0: return {"-", rand_operand(d + 1)};
				1: return {"~", rand_operand(d + 1)};
				default: return {"+", rand_operand(d + 1)};
			endcase
		end
		return {"(", rand_expr(d + 1), ")"};
	endfunction

	function automatic string rand_binop();
		case ($urandom_range(0, 10)) inside
			0: return "*";
			1: return "/";
			2: return "%";
			[3:4]: return "+";
			5: return "-";
			6: return "<<";
			7: return ">>";
			8: return "&";
			9: return "^";
			default: return "|";
		endcase
	endfunction

	function automatic string rand_expr(int d);
		string s;
		int n;
		n = $urandom_range(1, 3);
		s = rand_operand(d);
		for (int i = 1; i < n; i++) s = {s, rand_binop(), rand_operand(d)};
		return s;
	endfunction

	// stimulus
	initial begin
		string s, deep;
		int pos;
		ev_clear();
		add_expr("0");
		add_expr("2147483647");
		add_expr("0x7fffffff");
		add_expr("99999999999");
		add_expr("-2147483647");
		add_expr("(0-2147483647-1)/-1");
		add_expr("(0-2147483647-1)%-1");
		add_expr("7/0");
		add_expr("7%0");
		add_expr("1<<0");
		add_expr("3<<32");
		add_expr("-8>>1");
		add_expr("0x");
		add_expr("0x1g");
		add_expr("08");
		add_expr("1<2");
		add_expr("(1");
		add_expr("()");
		add_expr(" ");
		add_expr("1+2*3-4%3 ");
		add_expr("~5&3^2|8");
		add_expr("1 + ) ");
		add_expr("1 $ junk");
		add_expr("(1 $)");
		deep = "";
		for (int i = 0; i < 66; i++) deep = {deep, "("};
		add_expr({deep, "1"});

		// random expressions, mostly well formed
		while (pend_q.size() < 850) begin
			pos = $urandom_range(0, 99);
			if (pos < 80) begin
				add_expr(rand_expr(0));
			end else if (pos < 92) begin
				s = rand_expr(0);
				if (s.len() > 1 && $urandom_range(0, 1)) s = s.substr(0, s.len() - 2);
				else s = {s.substr(0, s.len() / 2), string'(byte'($urandom_range(0, 255))),
					s.substr(s.len() / 2 + 1, s.len() - 1)};
				add_expr(s);
			end else begin
				s = "";
				for (int i = 0; i < $urandom_range(1, 6); i++)
					s = {s, string'(byte'($urandom_range(1, 255)))};
				add_expr(s);
			end
		end

		wait (pend_q.size() == 0 && !s_tvalid && expected_q.size() == 0);
		repeat (300) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// driver
	always @(posedge clk) begin
		int pct;
		char_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			pct = (sent_cnt < 300) ? 30 : (sent_cnt < 600) ? 49 : 0;
			if (pend_q.size() > 0 && $urandom_range(0, 99) >= pct) begin
				it = pend_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= it.ch;
				s_tlast <= it.last;
				sent_cnt++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver with one long hold-off
	always @(posedge clk) begin
		int pct;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (!hold_done && sent_cnt >= 450) begin
			hold_done = 1;
			hold_cnt = 3000;
			m_tready <= 1'b0;
		end else begin
			pct = (sent_cnt < 300) ? 49 : (sent_cnt < 600) ? 30 : 0;
			m_tready <= ($urandom_range(0, 99) >= pct);
		end
	end

	// monitor and check
	always @(posedge clk) begin
		eval_res_t exp_r;
		if (arst_n) begin
			if (s_tvalid && s_tready) eval_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result value=%h ok=%b", m_tdata, m_tuser[0]);
				end else begin
					exp_r = expected_q.pop_front();
					if (m_tdata !== exp_r.value || m_tuser[0] !== exp_r.ok) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: exp value=%h ok=%b got value=%h ok=%b",
								exp_r.value, exp_r.ok, m_tdata, m_tuser[0]);
					end
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
